// ===== hdl/error_rate_circuit_breaker_top_defines.svh =====
// ----------------------------------------------------------------------------
// Error-rate circuit breaker assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ERROR_RATE_CIRCUIT_BREAKER_TOP_DEFINES_SVH
`define ERROR_RATE_CIRCUIT_BREAKER_TOP_DEFINES_SVH

// same-cycle implication
`define ERB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erb assertion failed");

// next-cycle implication
`define ERB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erb assertion failed");

`endif

// ===== hdl/erb_pkg.sv =====
// ----------------------------------------------------------------------------
// erb_pkg
// Types and constants of the error-rate circuit breaker.
// ----------------------------------------------------------------------------
package erb_pkg;

  localparam int COUNT_W = 16;
  localparam int TIME_W  = 48;
  localparam int SLEEP_W = 32;
  localparam int ROLL_W  = 32;
  localparam int VOL_W   = 16;
  localparam int PCT_W   = 7;
  localparam int MUL_W   = COUNT_W + PCT_W;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);

  // register indexes
  localparam logic [CFG_AW-1:0] REG_SLEEP  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ROLL   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_VOLUME = 2'd2;
  localparam logic [CFG_AW-1:0] REG_PCT    = 2'd3;

  // event kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_SUCCESS = 2'd1;
  localparam logic [1:0] KIND_FAILURE = 2'd2;
  localparam logic [1:0] KIND_RESET   = 2'd3;

  // breaker modes
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;
  localparam logic [1:0] MODE_STRAY  = 2'd3;

  typedef struct packed {
    logic [SLEEP_W-1:0] sleep_span;
    logic [ROLL_W-1:0]  roll_span;
    logic [VOL_W-1:0]   min_volume;
    logic [PCT_W-1:0]   error_percent_limit;
  } erb_cfg_t;

  typedef struct packed {
    logic [1:0] breaker_mode;
    logic       probe;
    logic       allowed;
  } erb_res_t;

endpackage

// ===== hdl/erb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// erb_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module erb_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [erb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [erb_pkg::CFG_DW-1:0] cfg_wdata,
  output erb_pkg::erb_cfg_t          cfg_o
);
  import erb_pkg::*;

  erb_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sleep_span          <= SLEEP_W'(5000);
      cfg_r.roll_span           <= ROLL_W'(60000);
      cfg_r.min_volume          <= VOL_W'(20);
      cfg_r.error_percent_limit <= PCT_W'(50);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SLEEP:  cfg_r.sleep_span          <= cfg_wdata[SLEEP_W-1:0];
        REG_ROLL:   cfg_r.roll_span           <= cfg_wdata[ROLL_W-1:0];
        REG_VOLUME: cfg_r.min_volume          <= cfg_wdata[VOL_W-1:0];
        REG_PCT:    cfg_r.error_percent_limit <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hdl/erb_core.sv =====
// ----------------------------------------------------------------------------
// erb_core
// Breaker state and combinational event evaluation.
// ----------------------------------------------------------------------------
`include "error_rate_circuit_breaker_top_defines.svh"

module erb_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_v,
  input  logic [1:0]                 kind,
  input  logic [erb_pkg::TIME_W-1:0] now_time,
  input  erb_pkg::erb_cfg_t          cfg,
  output erb_pkg::erb_res_t          res
);
  import erb_pkg::*;

  logic [1:0]         mode_r,   mode_nxt;
  logic [COUNT_W-1:0] total_r,  total_nxt;
  logic [COUNT_W-1:0] failed_r, failed_nxt;
  logic [TIME_W-1:0]  opened_r, opened_nxt;
  logic [TIME_W-1:0]  wbegin_r, wbegin_nxt;

  logic               win_exp;
  logic               sleep_done;
  logic [COUNT_W-1:0] t_roll, f_roll, t_inc, f_inc;
  logic [TIME_W-1:0]  wb_roll;
  logic [MUL_W-1:0]   fail_x100, lim_x_total;
  logic               trip;
  logic               allowed, canary;

  always_comb begin
    win_exp = (now_time >= wbegin_r) &&
              ((now_time - wbegin_r) >= {{(TIME_W-ROLL_W){1'b0}}, cfg.roll_span});
    sleep_done = (now_time > opened_r) &&
                 ((now_time - opened_r) > {{(TIME_W-SLEEP_W){1'b0}}, cfg.sleep_span});

    t_roll  = win_exp ? '0 : total_r;
    f_roll  = win_exp ? '0 : failed_r;
    wb_roll = win_exp ? now_time : wbegin_r;
    t_inc   = (t_roll == COUNT_MAX) ? t_roll : t_roll + COUNT_W'(1);
    f_inc   = (f_roll == COUNT_MAX) ? f_roll : f_roll + COUNT_W'(1);

    fail_x100   = MUL_W'(f_inc) * MUL_W'(PCT_FULL);
    lim_x_total = MUL_W'(cfg.error_percent_limit) * MUL_W'(t_inc);
    trip        = (t_inc >= cfg.min_volume) && (fail_x100 >= lim_x_total);

    mode_nxt   = mode_r;
    total_nxt  = total_r;
    failed_nxt = failed_r;
    opened_nxt = opened_r;
    wbegin_nxt = wbegin_r;
    allowed    = 1'b0;
    canary     = 1'b0;

    case (kind)
      KIND_REQUEST: begin
        if (mode_r == MODE_CLOSED) begin
          allowed = 1'b1;
        end else if (mode_r != MODE_HALF && sleep_done) begin
          mode_nxt = MODE_HALF;
          canary   = 1'b1;
        end
      end
      KIND_SUCCESS: begin
        if (mode_r == MODE_HALF) begin
          mode_nxt   = MODE_CLOSED;
          total_nxt  = '0;
          failed_nxt = '0;
          opened_nxt = '0;
          wbegin_nxt = now_time;
        end else begin
          wbegin_nxt = wb_roll;
          total_nxt  = t_inc;
          failed_nxt = f_roll;
        end
      end
      KIND_FAILURE: begin
        if (mode_r == MODE_HALF) begin
          mode_nxt   = MODE_OPEN;
          opened_nxt = now_time;
        end else begin
          wbegin_nxt = wb_roll;
          total_nxt  = t_inc;
          failed_nxt = f_inc;
          if (trip) begin
            mode_nxt   = MODE_OPEN;
            opened_nxt = now_time;
          end
        end
      end
      default: begin
        mode_nxt   = MODE_CLOSED;
        total_nxt  = '0;
        failed_nxt = '0;
        opened_nxt = '0;
        wbegin_nxt = now_time;
      end
    endcase

    res.allowed      = allowed;
    res.probe        = canary;
    res.breaker_mode = (mode_nxt == MODE_STRAY) ? MODE_OPEN : mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CLOSED;
      total_r  <= '0;
      failed_r <= '0;
      opened_r <= '0;
      wbegin_r <= '0;
    end else if (step_v) begin
      mode_r   <= mode_nxt;
      total_r  <= total_nxt;
      failed_r <= failed_nxt;
      opened_r <= opened_nxt;
      wbegin_r <= wbegin_nxt;
    end
  end

  `ERB_ASSERT_IMPL(a_fail_le_total, 1'b1, failed_r <= total_r)
  `ERB_ASSERT_NEXT(a_reset_clears, step_v && kind == KIND_RESET,
                   mode_r == MODE_CLOSED && total_r == '0 && failed_r == '0)
  `ERB_ASSERT_NEXT(a_idle_holds, !step_v,
                   $stable(mode_r) && $stable(total_r) && $stable(wbegin_r))
  `ERB_ASSERT_IMPL(a_canary_half, res.probe, res.breaker_mode == MODE_HALF && !res.allowed)

endmodule

// ===== hdl/error_rate_circuit_breaker_top.sv =====
// ----------------------------------------------------------------------------
// error_rate_circuit_breaker_top
// Closed/open/half-open circuit breaker with a rolling error-rate window.
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------
//   in_      | slave     | tuser: kind; tdata: now_time
//   out_     | master    | tdata: allowed, probe, breaker_mode
//   cfg_     | write     | index 0..3, 32-bit data
//
// One request per cycle sustained unless out_tready stalls; input register,
// then result register, with the single evaluation stage in erb_core between.
// Synchronous active-low reset clears both stages and the breaker state.
// A stalled result holds in the output register while the input register
// keeps its request; in_tready drops only when both are full.
// ----------------------------------------------------------------------------
module error_rate_circuit_breaker_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [erb_pkg::TIME_W-1:0] in_tdata,   // [47:0] now_time
  input  logic [1:0]                 in_tuser,   // [1:0] kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [0] allowed, [1] probe,
                                                 // [3:2] breaker_mode, [7:4] zero
  input  logic                       cfg_wr_en,
  input  logic [erb_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [erb_pkg::CFG_DW-1:0] cfg_wdata
);
  import erb_pkg::*;

  erb_cfg_t          cfg;
  erb_res_t          res;

  logic              s1_v_r;
  logic [1:0]        s1_kind_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              out_v_r;
  erb_res_t          out_res_r;

  logic              s2_free;
  logic              s1_move;

  assign s2_free   = !out_v_r || out_tready;
  assign s1_move   = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_now_r  <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  erb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  erb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_v   (s1_move),
    .kind     (s1_kind_r),
    .now_time (s1_now_r),
    .cfg      (cfg),
    .res      (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_res_r};

endmodule

// ===== verif/error_rate_circuit_breaker_top_test.sv =====
// ----------------------------------------------------------------------------
// error_rate_circuit_breaker_top_test
// Self-checking bench for the circuit breaker. Events stream in on the in_
// channel and a local breaker model predicts allowed, probe and the
// mode for each one. The checker compares every out_ result against the
// oldest prediction. Covers a directed trip/recover walk and randomized
// traffic under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module error_rate_circuit_breaker_top_test;
  import erb_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEMS_PER_PH = 228;
  localparam int NUM_PHASES   = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TIME_W-1:0]   in_tdata = '0;
  logic [1:0]          in_tuser = KIND_REQUEST;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = REG_SLEEP;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // breaker model: registers and state
  logic [SLEEP_W-1:0]  sleep_win;
  logic [ROLL_W-1:0]   roll_win;
  logic [VOL_W-1:0]    vol_min;
  logic [PCT_W-1:0]    pct_limit;
  logic [1:0]          mode_q;
  logic [COUNT_W-1:0]  total_q;
  logic [COUNT_W-1:0]  failed_q;
  logic [TIME_W-1:0]   opened_at;
  logic [TIME_W-1:0]   window_start;

  erb_res_t            pending_results[$];
  int                  fail_count = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic [TIME_W-1:0]   stamp = '0;

  error_rate_circuit_breaker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [47:0] now_time
    .in_tuser   (in_tuser),   // [1:0] kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] allowed, [1] probe, [3:2] breaker_mode
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void clear_breaker(input logic [TIME_W-1:0] ts);
    mode_q       = MODE_CLOSED;
    total_q      = '0;
    failed_q     = '0;
    opened_at    = '0;
    window_start = ts;
  endfunction

  function automatic void roll_window(input logic [TIME_W-1:0] ts);
    if (ts >= window_start && (ts - window_start) >= TIME_W'(roll_win)) begin
      window_start = ts;
      total_q      = '0;
      failed_q     = '0;
    end
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  function automatic erb_res_t next_breaker_result(input logic [1:0] kind,
                                                   input logic [TIME_W-1:0] ts);
    erb_res_t r;
    longint unsigned fail_prod;
    longint unsigned lim_prod;
    r = '0;
    case (kind)
      KIND_REQUEST: begin
        if (mode_q == MODE_CLOSED) begin
          r.allowed = 1'b1;
        end else if (mode_q == MODE_OPEN || mode_q == MODE_STRAY) begin
          if (ts > opened_at && (ts - opened_at) > TIME_W'(sleep_win)) begin
            mode_q  = MODE_HALF;
            r.probe = 1'b1;
          end
        end
      end
      KIND_SUCCESS: begin
        if (mode_q == MODE_HALF) begin
          clear_breaker(ts);
        end else begin
          roll_window(ts);
          total_q = sat_inc(total_q);
        end
      end
      KIND_FAILURE: begin
        if (mode_q == MODE_HALF) begin
          mode_q    = MODE_OPEN;
          opened_at = ts;
        end else begin
          roll_window(ts);
          total_q   = sat_inc(total_q);
          failed_q  = sat_inc(failed_q);
          fail_prod = longint'(failed_q) * 100;
          lim_prod  = longint'(pct_limit) * longint'(total_q);
          if (total_q >= vol_min && fail_prod >= lim_prod) begin
            mode_q    = MODE_OPEN;
            opened_at = ts;
          end
        end
      end
      default: clear_breaker(ts);
    endcase
    r.breaker_mode = (mode_q == MODE_STRAY) ? MODE_OPEN : mode_q;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    erb_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_tdata %h", out_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[0] !== exp_r.allowed) begin
          $error("allowed: expected %0d, actual %0d", exp_r.allowed, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== exp_r.probe) begin
          $error("probe: expected %0d, actual %0d", exp_r.probe, out_tdata[1]);
          fail_count++;
        end
        if (out_tdata[3:2] !== exp_r.breaker_mode) begin
          $error("breaker_mode: expected %0d, actual %0d", exp_r.breaker_mode,
                 out_tdata[3:2]);
          fail_count++;
        end
        if (out_tdata[7:4] !== 4'h0) begin
          $error("pad: expected 0, actual %0h", out_tdata[7:4]);
          fail_count++;
        end
      end
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [TIME_W-1:0] ts);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ts;
    in_tuser  = kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(next_breaker_result(kind, ts));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    case (idx)
      REG_SLEEP:  sleep_win = val[SLEEP_W-1:0];
      REG_ROLL:   roll_win  = val[ROLL_W-1:0];
      REG_VOLUME: vol_min   = val[VOL_W-1:0];
      default:    pct_limit = val[PCT_W-1:0];
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] sleep_v, input logic [31:0] roll_v,
                            input logic [15:0] vol_v, input logic [6:0] pct_v);
    wait_results_done();
    cfg_write(REG_SLEEP, sleep_v);
    cfg_write(REG_ROLL, roll_v);
    cfg_write(REG_VOLUME, CFG_DW'(vol_v));
    cfg_write(REG_PCT, CFG_DW'(pct_v));
  endtask

  task automatic test_trip_and_recover();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_event(KIND_REQUEST, 48'd0);
    set_config(32'd10, 32'd100, 16'd2, 7'd50);
    send_event(KIND_FAILURE, 48'd5);
    send_event(KIND_FAILURE, 48'd6);      // trips
    send_event(KIND_REQUEST, 48'd10);
    send_event(KIND_REQUEST, 48'd16);     // exactly sleep window: still open
    send_event(KIND_REQUEST, 48'd17);     // canary
    send_event(KIND_REQUEST, 48'd18);
    send_event(KIND_FAILURE, 48'd20);     // half-open failure reopens
    send_event(KIND_REQUEST, 48'd31);
    send_event(KIND_SUCCESS, 48'd32);     // half-open success closes
    send_event(KIND_SUCCESS, 48'd40);
    send_event(KIND_FAILURE, 48'd132);    // window expired
    send_event(KIND_FAILURE, 48'd133);
    send_event(KIND_REQUEST, 48'd100);    // time before opened
    send_event(KIND_SUCCESS, 48'd134);    // counted while open
    send_event(KIND_FAILURE, 48'd135);    // retrip restarts open time
    send_event(KIND_REQUEST, 48'd145);
    send_event(KIND_REQUEST, 48'd146);
    send_event(KIND_RESET, {TIME_W{1'b1}});
    send_event(KIND_FAILURE, 48'd5);      // earlier than window start
    send_event(KIND_REQUEST, {TIME_W{1'b1}});
    send_event(KIND_FAILURE, 48'd6);
    send_event(KIND_REQUEST, {TIME_W{1'b1}});
    send_event(KIND_SUCCESS, {TIME_W{1'b1}});
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    int fail_w;
    int sel;
    logic [1:0] kind;
    logic [63:0] jump;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_config(32'd0, 32'd1, 16'd0, 7'd0);
        1:       set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 7'd100);
        2:       set_config(32'($urandom_range(0, 300)), 32'd50, 16'd3, 7'd127);
        default: set_config(32'($urandom_range(0, 300)), 32'($urandom_range(1, 800)),
                            16'($urandom_range(0, 12)), 7'($urandom_range(0, 100)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      fail_w = $urandom_range(15, 60);
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        if (n == ITEMS_PER_PH / 2) wait_results_done();
        sel = $urandom_range(99);
        if (sel < 4) kind = KIND_RESET;
        else if (sel < 4 + fail_w) kind = KIND_FAILURE;
        else if ($urandom_range(1)) kind = KIND_REQUEST;
        else kind = KIND_SUCCESS;
        sel = $urandom_range(99);
        if (sel < 60) begin
          stamp = stamp + TIME_W'($urandom_range(0, 3));
        end else if (sel < 75) begin
          stamp = stamp + ((sleep_win > 1000) ? TIME_W'($urandom_range(0, 5))
                                              : TIME_W'(sleep_win) +
                                                TIME_W'($urandom_range(0, 2)));
        end else if (sel < 88) begin
          stamp = stamp + ((roll_win > 1000) ? TIME_W'($urandom_range(0, 5))
                                             : TIME_W'(roll_win) - TIME_W'(1) +
                                               TIME_W'($urandom_range(0, 2)));
        end else if (sel < 95) begin
          stamp = stamp - TIME_W'($urandom_range(0, 20));
        end else begin
          jump  = {$urandom, $urandom};
          stamp = TIME_W'(jump);
        end
        send_event(kind, stamp);
      end
    end
    wait_results_done();
  endtask

  initial begin
    sleep_win = 32'd5000;
    roll_win  = 32'd60000;
    vol_min   = 16'd20;
    pct_limit = 7'd50;
    clear_breaker('0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_trip_and_recover();
    test_random_traffic();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/erb_pkg.sv
hdl/erb_cfg_regs.sv
hdl/erb_core.sv
hdl/error_rate_circuit_breaker_top.sv
verif/error_rate_circuit_breaker_top_test.sv
